// ===== sv/assert_macros.svh =====
// assertion macros used by the guidance rtl (slcg_ctrl)
// no dependencies; expects clk_i and rst_ni in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, ante, cons) lbl: assert property (@(posedge clk_i) \
  disable iff (!rst_ni) (ante) |=> (cons)) else $error("assertion failed");
`define ASSERT_NEVER(lbl, expr) lbl: assert property (@(posedge clk_i) \
  disable iff (!rst_ni) !(expr)) else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== sv/slcg_pkg.sv =====
// types, constants and the cordic angle table for the course guidance block
// no dependencies
package slcg_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W = $clog2(CORDIC_STEPS);

  localparam logic signed [19:0] PI_Q16      = 20'sd205887;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic [17:0] INV_GAIN_Q16    = 18'd39797;
  localparam logic [17:0] TWO_OVER_PI_Q16 = 18'd41722;

  localparam logic [14:0] RST_APPROACH = 15'd12868;
  localparam logic [15:0] RST_XT_GAIN  = 16'd256;
  localparam logic [15:0] RST_INT_GAIN = 16'd0;
  localparam logic [15:0] RST_STEP     = 16'd655;

  typedef enum logic [2:0] {
    CFG_APPROACH  = 3'd0,
    CFG_XT_GAIN   = 3'd1,
    CFG_INT_GAIN  = 3'd2,
    CFG_STEP      = 3'd3,
    CFG_START_N   = 3'd4,
    CFG_START_E   = 3'd5,
    CFG_END_N     = 3'd6,
    CFG_END_E     = 3'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_P_INIT, OP_VEC, OP_R_INIT, OP_ROT, OP_E_MUL, OP_E_SAT,
    OP_I_MUL, OP_I_ADD, OP_A_MUL, OP_A_INIT, OP_F_MUL, OP_F_RND, OP_AP_MUL,
    OP_AP_RND, OP_G_LO, OP_G_HI, OP_OUT
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_P_INIT, ST_P_ITER, ST_R_INIT, ST_R_ITER, ST_E_MUL, ST_E_SAT,
    ST_I_MUL, ST_I_ADD, ST_A_MUL, ST_A_INIT, ST_A_ITER, ST_F_MUL, ST_F_RND,
    ST_AP_MUL, ST_AP_RND, ST_G_LO, ST_G_HI, ST_DONE
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [ITER_W-1:0] iter;
  } cmd_t;

  function automatic logic [15:0] atan_tab(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30386;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/slcg_datapath.sv =====
// datapath: config registers, shared cordic unit, multiplier, integral state
// depends on slcg_pkg
module slcg_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slcg_pkg::cmd_t      cmd_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic signed [31:0]  pos_north_i,
  input  logic signed [31:0]  pos_east_i,
  input  logic                clear_i,
  output logic signed [15:0]  course_o,
  output logic signed [31:0]  xt_err_o,
  output logic                int_sat_o
);

  logic [14:0] aam_q;
  logic [15:0] xtg_q, ig_q, ts_q;
  logic signed [31:0] sn_q, se_q, en_q, ee_q;

  logic signed [51:0] x_q, x_d, y_q, y_d;
  logic signed [19:0] z_q, z_d, chi_q, chi_d, frac_q, frac_d;
  logic signed [20:0] appr_q, appr_d;
  logic signed [31:0] pn_q, pn_d, pe_q, pe_d, err_q, err_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [47:0] ei_q, ei_d;
  logic               hit_q, hit_d, degen_q, degen_d;
  logic signed [15:0] course_q, course_d;
  logic signed [31:0] xte_q, xte_d;
  logic               isat_q, isat_d;

  logic signed [35:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [53:0] mul_p;

  logic signed [51:0] xs, ys, dx, dy;
  logic signed [19:0] tab, zr;
  logic signed [63:0] r64, integ, crs;
  logic signed [48:0] sum49;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aam_q <= slcg_pkg::RST_APPROACH;
      xtg_q <= slcg_pkg::RST_XT_GAIN;
      ig_q  <= slcg_pkg::RST_INT_GAIN;
      ts_q  <= slcg_pkg::RST_STEP;
      sn_q  <= '0;
      se_q  <= '0;
      en_q  <= '0;
      ee_q  <= '0;
      ei_q  <= '0;
    end else begin
      ei_q <= ei_d;
      if (cfg_we_i) begin
        unique case (slcg_pkg::cfg_idx_e'(cfg_idx_i))
          slcg_pkg::CFG_APPROACH: aam_q <= cfg_wdata_i[14:0];
          slcg_pkg::CFG_XT_GAIN:  xtg_q <= cfg_wdata_i[15:0];
          slcg_pkg::CFG_INT_GAIN: ig_q  <= cfg_wdata_i[15:0];
          slcg_pkg::CFG_STEP:     ts_q  <= cfg_wdata_i[15:0];
          slcg_pkg::CFG_START_N:  sn_q  <= cfg_wdata_i;
          slcg_pkg::CFG_START_E:  se_q  <= cfg_wdata_i;
          slcg_pkg::CFG_END_N:    en_q  <= cfg_wdata_i;
          slcg_pkg::CFG_END_E:    ee_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    chi_q    <= chi_d;
    frac_q   <= frac_d;
    appr_q   <= appr_d;
    pn_q     <= pn_d;
    pe_q     <= pe_d;
    err_q    <= err_d;
    prod_q   <= prod_d;
    hit_q    <= hit_d;
    degen_q  <= degen_d;
    course_q <= course_d;
    xte_q    <= xte_d;
    isat_q   <= isat_d;
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      slcg_pkg::OP_E_MUL: begin
        mul_a = y_q[35:0];
        mul_b = $signed(slcg_pkg::INV_GAIN_Q16);
      end
      slcg_pkg::OP_I_MUL: begin
        mul_a = 36'(err_q);
        mul_b = $signed({2'b00, ts_q});
      end
      slcg_pkg::OP_A_MUL: begin
        mul_a = 36'(err_q);
        mul_b = $signed({2'b00, xtg_q});
      end
      slcg_pkg::OP_F_MUL: begin
        mul_a = 36'(z_q);
        mul_b = $signed(slcg_pkg::TWO_OVER_PI_Q16);
      end
      slcg_pkg::OP_AP_MUL: begin
        mul_a = 36'(frac_q);
        mul_b = $signed({3'b000, aam_q});
      end
      slcg_pkg::OP_G_LO: begin
        mul_a = $signed({12'd0, ei_q[23:0]});
        mul_b = $signed({2'b00, ig_q});
      end
      slcg_pkg::OP_G_HI: begin
        mul_a = 36'($signed(ei_q[47:24]));
        mul_b = $signed({2'b00, ig_q});
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    x_d = x_q;  y_d = y_q;  z_d = z_q;
    chi_d = chi_q;  frac_d = frac_q;  appr_d = appr_q;
    pn_d = pn_q;  pe_d = pe_q;  err_d = err_q;
    prod_d = prod_q;  ei_d = ei_q;  hit_d = hit_q;  degen_d = degen_q;
    course_d = course_q;  xte_d = xte_q;  isat_d = isat_q;

    xs  = x_q >>> cmd_i.iter;
    ys  = y_q >>> cmd_i.iter;
    tab = $signed({4'd0, slcg_pkg::atan_tab(5'(cmd_i.iter))});
    dx  = 52'(en_q) - 52'(sn_q);
    dy  = 52'(ee_q) - 52'(se_q);
    zr  = '0;
    r64 = '0;
    integ = '0;
    crs = '0;
    sum49 = '0;

    case (cmd_i.op)
      slcg_pkg::OP_LOAD: begin
        pn_d = pos_north_i;
        pe_d = pos_east_i;
        if (clear_i) ei_d = '0;
      end
      slcg_pkg::OP_P_INIT: begin
        degen_d = (dx == '0) && (dy == '0);
        if (dx < 0) begin
          z_d = (dy >= 0) ? slcg_pkg::PI_Q16 : -slcg_pkg::PI_Q16;
          x_d = -dx;
          y_d = -dy;
        end else begin
          z_d = '0;
          x_d = dx;
          y_d = dy;
        end
      end
      slcg_pkg::OP_VEC: begin
        if (y_q >= 0) begin
          x_d = x_q + ys;  y_d = y_q - xs;  z_d = z_q + tab;
        end else begin
          x_d = x_q - ys;  y_d = y_q + xs;  z_d = z_q - tab;
        end
      end
      slcg_pkg::OP_R_INIT: begin
        chi_d = degen_q ? '0 : z_q;
        zr    = degen_q ? '0 : -z_q;
        x_d   = 52'(pn_q) - 52'(sn_q);
        y_d   = 52'(pe_q) - 52'(se_q);
        if (zr > slcg_pkg::HALF_PI_Q16) begin
          x_d = 52'(sn_q) - 52'(pn_q);
          y_d = 52'(se_q) - 52'(pe_q);
          zr  = zr - slcg_pkg::PI_Q16;
        end else if (zr < -slcg_pkg::HALF_PI_Q16) begin
          x_d = 52'(sn_q) - 52'(pn_q);
          y_d = 52'(se_q) - 52'(pe_q);
          zr  = zr + slcg_pkg::PI_Q16;
        end
        z_d = zr;
      end
      slcg_pkg::OP_ROT: begin
        if (z_q >= 0) begin
          x_d = x_q - ys;  y_d = y_q + xs;  z_d = z_q - tab;
        end else begin
          x_d = x_q + ys;  y_d = y_q - xs;  z_d = z_q + tab;
        end
      end
      slcg_pkg::OP_E_MUL, slcg_pkg::OP_I_MUL, slcg_pkg::OP_A_MUL, slcg_pkg::OP_F_MUL,
      slcg_pkg::OP_AP_MUL, slcg_pkg::OP_G_LO: begin
        prod_d = 64'(mul_p);
      end
      slcg_pkg::OP_G_HI: begin
        prod_d = prod_q + (64'(mul_p) <<< 24);
      end
      slcg_pkg::OP_E_SAT: begin
        r64 = (prod_q + 64'sd32768) >>> 16;
        if (r64 > 64'sd2147483647)       err_d = 32'sh7FFFFFFF;
        else if (r64 < -64'sd2147483648) err_d = 32'sh80000000;
        else                             err_d = r64[31:0];
      end
      slcg_pkg::OP_I_ADD: begin
        r64   = (prod_q + 64'sd128) >>> 8;
        sum49 = 49'(ei_q) + 49'(r64);
        if (sum49 > 49'sh0_7FFF_FFFF_FFFF) begin
          ei_d = 48'sh7FFF_FFFF_FFFF;  hit_d = 1'b1;
        end else if (sum49 < -49'sh0_8000_0000_0000) begin
          ei_d = 48'sh8000_0000_0000;  hit_d = 1'b1;
        end else begin
          ei_d  = sum49[47:0];
          hit_d = (sum49[47:0] == 48'sh7FFF_FFFF_FFFF) ||
                  (sum49[47:0] == 48'sh8000_0000_0000);
        end
      end
      slcg_pkg::OP_A_INIT: begin
        x_d = 52'sd65536;
        y_d = prod_q[51:0];
        z_d = '0;
      end
      slcg_pkg::OP_F_RND: begin
        r64    = (prod_q + 64'sd32768) >>> 16;
        frac_d = r64[19:0];
      end
      slcg_pkg::OP_AP_RND: begin
        r64    = (prod_q + 64'sd8192) >>> 14;
        appr_d = r64[20:0];
      end
      slcg_pkg::OP_OUT: begin
        integ = (prod_q + 64'sd128) >>> 8;
        crs   = 64'(chi_q) - 64'(appr_q) - integ;
        r64   = (crs + 64'sd8) >>> 4;
        if (r64 > 64'sd32767)       course_d = 16'sh7FFF;
        else if (r64 < -64'sd32768) course_d = 16'sh8000;
        else                        course_d = r64[15:0];
        xte_d  = err_q;
        isat_d = hit_q;
      end
      default: ;
    endcase
  end

  assign course_o  = course_q;
  assign xt_err_o  = xte_q;
  assign int_sat_o = isat_q;

endmodule

// ===== sv/slcg_ctrl.sv =====
// controller: sequences cordic passes and multiplies, owns the stream handshakes
// depends on slcg_pkg and assert_macros.svh
`include "assert_macros.svh"
module slcg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output slcg_pkg::cmd_t cmd_o
);

  slcg_pkg::state_e state_q, state_d;
  logic [slcg_pkg::ITER_W-1:0] cnt_q, cnt_d;
  logic m_valid_q, m_valid_d;
  logic last;

  assign last = (cnt_q == slcg_pkg::ITER_W'(slcg_pkg::CORDIC_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= slcg_pkg::ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slcg_pkg::ST_IDLE:   if (in_valid_i) state_d = slcg_pkg::ST_P_INIT;
      slcg_pkg::ST_P_INIT: state_d = slcg_pkg::ST_P_ITER;
      slcg_pkg::ST_P_ITER: if (last) state_d = slcg_pkg::ST_R_INIT;
      slcg_pkg::ST_R_INIT: state_d = slcg_pkg::ST_R_ITER;
      slcg_pkg::ST_R_ITER: if (last) state_d = slcg_pkg::ST_E_MUL;
      slcg_pkg::ST_E_MUL:  state_d = slcg_pkg::ST_E_SAT;
      slcg_pkg::ST_E_SAT:  state_d = slcg_pkg::ST_I_MUL;
      slcg_pkg::ST_I_MUL:  state_d = slcg_pkg::ST_I_ADD;
      slcg_pkg::ST_I_ADD:  state_d = slcg_pkg::ST_A_MUL;
      slcg_pkg::ST_A_MUL:  state_d = slcg_pkg::ST_A_INIT;
      slcg_pkg::ST_A_INIT: state_d = slcg_pkg::ST_A_ITER;
      slcg_pkg::ST_A_ITER: if (last) state_d = slcg_pkg::ST_F_MUL;
      slcg_pkg::ST_F_MUL:  state_d = slcg_pkg::ST_F_RND;
      slcg_pkg::ST_F_RND:  state_d = slcg_pkg::ST_AP_MUL;
      slcg_pkg::ST_AP_MUL: state_d = slcg_pkg::ST_AP_RND;
      slcg_pkg::ST_AP_RND: state_d = slcg_pkg::ST_G_LO;
      slcg_pkg::ST_G_LO:   state_d = slcg_pkg::ST_G_HI;
      slcg_pkg::ST_G_HI:   state_d = slcg_pkg::ST_DONE;
      slcg_pkg::ST_DONE:   if (!m_valid_q || out_ready_i) state_d = slcg_pkg::ST_IDLE;
      default:             state_d = slcg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = slcg_pkg::OP_NONE;
    cmd_o.iter = cnt_q;
    cnt_d      = '0;
    in_ready_o = 1'b0;
    m_valid_d  = m_valid_q && !out_ready_i;
    unique case (state_q)
      slcg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = slcg_pkg::OP_LOAD;
      end
      slcg_pkg::ST_P_INIT: cmd_o.op = slcg_pkg::OP_P_INIT;
      slcg_pkg::ST_P_ITER: begin
        cmd_o.op = slcg_pkg::OP_VEC;
        cnt_d    = last ? '0 : cnt_q + 1'b1;
      end
      slcg_pkg::ST_R_INIT: cmd_o.op = slcg_pkg::OP_R_INIT;
      slcg_pkg::ST_R_ITER: begin
        cmd_o.op = slcg_pkg::OP_ROT;
        cnt_d    = last ? '0 : cnt_q + 1'b1;
      end
      slcg_pkg::ST_E_MUL:  cmd_o.op = slcg_pkg::OP_E_MUL;
      slcg_pkg::ST_E_SAT:  cmd_o.op = slcg_pkg::OP_E_SAT;
      slcg_pkg::ST_I_MUL:  cmd_o.op = slcg_pkg::OP_I_MUL;
      slcg_pkg::ST_I_ADD:  cmd_o.op = slcg_pkg::OP_I_ADD;
      slcg_pkg::ST_A_MUL:  cmd_o.op = slcg_pkg::OP_A_MUL;
      slcg_pkg::ST_A_INIT: cmd_o.op = slcg_pkg::OP_A_INIT;
      slcg_pkg::ST_A_ITER: begin
        cmd_o.op = slcg_pkg::OP_VEC;
        cnt_d    = last ? '0 : cnt_q + 1'b1;
      end
      slcg_pkg::ST_F_MUL:  cmd_o.op = slcg_pkg::OP_F_MUL;
      slcg_pkg::ST_F_RND:  cmd_o.op = slcg_pkg::OP_F_RND;
      slcg_pkg::ST_AP_MUL: cmd_o.op = slcg_pkg::OP_AP_MUL;
      slcg_pkg::ST_AP_RND: cmd_o.op = slcg_pkg::OP_AP_RND;
      slcg_pkg::ST_G_LO:   cmd_o.op = slcg_pkg::OP_G_LO;
      slcg_pkg::ST_G_HI:   cmd_o.op = slcg_pkg::OP_G_HI;
      slcg_pkg::ST_DONE: begin
        if (!m_valid_q || out_ready_i) begin
          cmd_o.op  = slcg_pkg::OP_OUT;
          m_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = m_valid_q;

  `ASSERT_IMPLY(a_busy_after_beat, in_valid_i && in_ready_o, !in_ready_o)
  `ASSERT_IMPLY(a_result_shown, state_q == slcg_pkg::ST_DONE && !m_valid_q, m_valid_q)
  `ASSERT_NEVER(a_cnt_idle, state_q != slcg_pkg::ST_P_ITER && state_q != slcg_pkg::ST_R_ITER && state_q != slcg_pkg::ST_A_ITER && cnt_q != '0)

endmodule

// ===== sv/straight_line_course_guidance.sv =====
// straight-line course guidance: one position beat in, one course command beat out
// each result comes from three passes of the shared cordic unit plus
// multiply and rounding steps
// one item at a time: the next input beat is taken only after the last item's
// result has entered the output register, where it waits while the next item runs
// async active-low reset restores register defaults and clears the error integral
module straight_line_course_guidance (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // position_north, position_east
  input  logic        s_axis_tuser,  // clear_integral
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // course_command, cross_track_error
  output logic        m_axis_tuser,  // integral_saturated
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  slcg_pkg::cmd_t     cmd;
  logic signed [15:0] course;
  logic signed [31:0] xt_err;

  slcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  slcg_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pos_north_i (s_axis_tdata[31:0]),
    .pos_east_i  (s_axis_tdata[63:32]),
    .clear_i     (s_axis_tuser),
    .course_o    (course),
    .xt_err_o    (xt_err),
    .int_sat_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {xt_err, course};

endmodule

// ===== tb/straight_line_course_guidance_test.sv =====
// testbench for straight_line_course_guidance: drives position beats, predicts each
// course command beat with a bit-true fixed-point model and checks it on arrival
// depends on slcg_pkg and the straight_line_course_guidance rtl
module straight_line_course_guidance_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] course;
    logic signed [31:0] xt_err;
    logic               sat_hit;
  } guidance_t;

  localparam longint INT48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INT48_MIN = -INT48_MAX - 1;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // position_north, position_east
  logic        s_axis_tuser = 1'b0;  // clear_integral
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;  // course_command, cross_track_error
  logic        m_axis_tuser;  // integral_saturated
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  guidance_t course_expected_q[$];
  int        mismatches = 0;
  int        out_stall = 0;
  int        hold_cycles = 0;
  bit        no_idle = 1'b0;

  // model copy of registers and integral
  longint approach_max, xt_gain, int_gain, step_s, st_n, st_e, en_n, en_e;
  longint err_integral;

  straight_line_course_guidance i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint cordic_angle(longint y, longint x);
    longint z, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(slcg_pkg::PI_Q16) : -longint'(slcg_pkg::PI_Q16);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < slcg_pkg::CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += longint'(slcg_pkg::atan_tab(5'(i)));
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= longint'(slcg_pkg::atan_tab(5'(i)));
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic longint cordic_rotate_y(longint x, longint y, longint z);
    longint nx, ny;
    if (z > longint'(slcg_pkg::HALF_PI_Q16)) begin
      x = -x; y = -y; z -= longint'(slcg_pkg::PI_Q16);
    end else if (z < -longint'(slcg_pkg::HALF_PI_Q16)) begin
      x = -x; y = -y; z += longint'(slcg_pkg::PI_Q16);
    end
    for (int i = 0; i < slcg_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= longint'(slcg_pkg::atan_tab(5'(i)));
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += longint'(slcg_pkg::atan_tab(5'(i)));
      end
      x = nx;
      y = ny;
    end
    return y;
  endfunction

  function automatic guidance_t predict_guidance(logic [31:0] pos_n, logic [31:0] pos_e,
                                                 logic clr);
    guidance_t r;
    longint chi, ry, err, t, frac, appr, integ, course;
    if (clr) err_integral = 0;
    chi = cordic_angle(en_e - st_e, en_n - st_n);
    ry = cordic_rotate_y(longint'($signed(pos_n)) - st_n, longint'($signed(pos_e)) - st_e,
                         -chi);
    err = clamp(rnd_shift(ry * longint'(slcg_pkg::INV_GAIN_Q16), 16), I32_MIN, I32_MAX);
    err_integral = clamp(err_integral + rnd_shift(err * step_s, 8), INT48_MIN, INT48_MAX);
    t = cordic_angle(err * xt_gain, 65536);
    frac = rnd_shift(t * longint'(slcg_pkg::TWO_OVER_PI_Q16), 16);
    appr = rnd_shift(frac * approach_max, 14);
    integ = rnd_shift(err_integral * int_gain, 8);
    course = clamp(rnd_shift(chi - appr - integ, 4), -32768, 32767);
    r.course = course[15:0];
    r.xt_err = err[31:0];
    r.sat_hit = (err_integral == INT48_MIN || err_integral == INT48_MAX);
    return r;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    guidance_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (course_expected_q.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        want = course_expected_q.pop_front();
        if ($signed(m_axis_tdata[15:0]) !== want.course)
          report("course_command", $signed(m_axis_tdata[15:0]), want.course);
        if ($signed(m_axis_tdata[47:16]) !== want.xt_err)
          report("cross_track_error", $signed(m_axis_tdata[47:16]), want.xt_err);
        if (m_axis_tuser !== want.sat_hit)
          report("integral_saturated", m_axis_tuser, want.sat_hit);
      end
      out_stall = draw_gap();
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready = 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic send_position(logic [31:0] pos_n, logic [31:0] pos_e, logic clr);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {pos_e, pos_n};
    s_axis_tuser = clr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    course_expected_q.push_back(predict_guidance(pos_n, pos_e, clr));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (course_expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(slcg_pkg::cfg_idx_e idx, logic [31:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      slcg_pkg::CFG_APPROACH: approach_max = longint'(v[14:0]);
      slcg_pkg::CFG_XT_GAIN:  xt_gain = longint'(v[15:0]);
      slcg_pkg::CFG_INT_GAIN: int_gain = longint'(v[15:0]);
      slcg_pkg::CFG_STEP:     step_s = longint'(v[15:0]);
      slcg_pkg::CFG_START_N:  st_n = longint'($signed(v));
      slcg_pkg::CFG_START_E:  st_e = longint'($signed(v));
      slcg_pkg::CFG_END_N:    en_n = longint'($signed(v));
      default:                en_e = longint'($signed(v));
    endcase
  endtask

  task automatic set_path(logic [31:0] sn, logic [31:0] se, logic [31:0] nn, logic [31:0] ne);
    write_reg(slcg_pkg::CFG_START_N, sn);
    write_reg(slcg_pkg::CFG_START_E, se);
    write_reg(slcg_pkg::CFG_END_N, nn);
    write_reg(slcg_pkg::CFG_END_E, ne);
  endtask

  function automatic logic [31:0] rand_coord(bit wide);
    return wide ? $urandom() : 32'($signed($urandom_range(0, 131072)) - 65536);
  endfunction

  // reset values, field extremes, degenerate path
  task automatic test_defaults();
    send_position(32'h0, 32'h0, 1'b0);
    send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_position(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_position(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_position(32'h0000_0100, 32'hFFFF_FF00, 1'b0);
    send_position(32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
  endtask

  // paths pointing into the left half plane, along the axes and across the full range
  task automatic test_path_directions();
    set_path(32'h0, 32'h0, -32'sd25600, 32'sd100);
    send_position(32'h1000, 32'h2000, 1'b0);
    set_path(32'h0, 32'h0, -32'sd25600, -32'sd100);
    send_position(32'hFFFF_1000, 32'h2000, 1'b0);
    set_path(32'h0, 32'h0, -32'sd25600, 32'sd0);
    send_position(32'h500, 32'hFFFF_F000, 1'b0);
    set_path(32'h0, 32'h0, 32'sd0, -32'sd25600);
    send_position(32'h500, 32'h500, 1'b0);
    set_path(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_position(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
  endtask

  // zero time step, angle above range, gain extremes
  task automatic test_gain_extremes();
    set_path(32'h0, 32'h0, 32'sd2560, 32'sd2560);
    write_reg(slcg_pkg::CFG_STEP, 32'h0);
    write_reg(slcg_pkg::CFG_INT_GAIN, 32'hFFFF);
    send_position(32'h0, 32'h4000, 1'b0);
    send_position(32'h0, 32'hFFFF_C000, 1'b0);
    write_reg(slcg_pkg::CFG_APPROACH, 32'h7FFF);
    write_reg(slcg_pkg::CFG_XT_GAIN, 32'hFFFF);
    write_reg(slcg_pkg::CFG_STEP, 32'hFFFF);
    send_position(32'h0, 32'h7FFF_FFFF, 1'b0);
    write_reg(slcg_pkg::CFG_APPROACH, 32'h0);
    write_reg(slcg_pkg::CFG_XT_GAIN, 32'h0);
    send_position(32'h0, 32'h8000_0000, 1'b1);
    write_reg(slcg_pkg::CFG_APPROACH, 32'd25736);
    write_reg(slcg_pkg::CFG_XT_GAIN, 32'd256);
    write_reg(slcg_pkg::CFG_INT_GAIN, 32'h0);
  endtask

  // drive the integral into both limits, then clear it
  task automatic test_integral_limit();
    set_path(32'h0, 32'h0, 32'h0, 32'h0);
    write_reg(slcg_pkg::CFG_STEP, 32'hFFFF);
    write_reg(slcg_pkg::CFG_INT_GAIN, 32'd300);
    no_idle = 1'b1;
    for (int i = 0; i < 270; i++) send_position($urandom(), 32'h7FFF_FFFF, i == 0);
    for (int i = 0; i < 10; i++) send_position(32'h0, 32'h8000_0000, i == 0);
    for (int i = 0; i < 260; i++) send_position($urandom(), 32'h8000_0000, 1'b0);
    send_position(32'h0, 32'h100, 1'b1);
    no_idle = 1'b0;
  endtask

  // receiver holds off while items keep coming
  task automatic test_output_hold();
    drain();
    hold_cycles = 600;
    for (int i = 0; i < 6; i++) send_position($urandom(), $urandom(), $urandom_range(0, 1));
  endtask

  task automatic test_random();
    bit wide;
    for (int ph = 0; ph < 6; ph++) begin
      wide = ph[0];
      set_path(rand_coord(wide), rand_coord(wide), rand_coord(wide), rand_coord(wide));
      write_reg(slcg_pkg::CFG_APPROACH, $urandom_range(0, 32767));
      write_reg(slcg_pkg::CFG_XT_GAIN, ph == 2 ? 32'hFFFF : $urandom_range(0, 1024));
      write_reg(slcg_pkg::CFG_INT_GAIN, ph == 3 ? 32'hFFFF : $urandom_range(0, 512));
      write_reg(slcg_pkg::CFG_STEP, ph == 4 ? 32'd1 : $urandom_range(1, 65535));
      no_idle = (ph == 5);
      for (int i = 0; i < 55; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_position($urandom(), $urandom(), $urandom_range(0, 7) == 0);
        else
          send_position(32'(en_n + $signed(rand_coord(1'b0))),
                        32'(en_e + $signed(rand_coord(1'b0))), $urandom_range(0, 7) == 0);
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    approach_max = longint'(slcg_pkg::RST_APPROACH);
    xt_gain = longint'(slcg_pkg::RST_XT_GAIN);
    int_gain = longint'(slcg_pkg::RST_INT_GAIN);
    step_s = longint'(slcg_pkg::RST_STEP);
    st_n = 0; st_e = 0; en_n = 0; en_e = 0;
    err_integral = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_defaults();
    test_path_directions();
    test_gain_extremes();
    test_integral_limit();
    test_output_hold();
    test_random();
    drain();
    repeat (70) @(posedge clk_i);
    if (mismatches == 0 && course_expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/slcg_pkg.sv
sv/slcg_datapath.sv
sv/slcg_ctrl.sv
sv/straight_line_course_guidance.sv
tb/straight_line_course_guidance_test.sv
